>>> rtl/kwtc_pkg.sv
// Shared types, constants and helpers for the keyword token counter.
// No dependencies; imported by kwtc_match and keyword_token_counter_core.
package kwtc_pkg;

  localparam int unsigned NumKeywords = 4;
  localparam int unsigned MaxWordLen  = 8;
  localparam int unsigned KeyRegs     = 4;
  localparam int unsigned CharW       = 8;
  localparam int unsigned KeyW        = CharW * MaxWordLen;
  localparam int unsigned LenW        = 4;
  localparam int unsigned LensW       = LenW * KeyRegs;
  localparam int unsigned CntW        = 32;
  localparam int unsigned MatchW      = 3;
  localparam int unsigned InUseW      = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = KeyW;
  localparam int unsigned PosW        = $clog2(MaxWordLen) > 0 ? $clog2(MaxWordLen) : 1;
  localparam int unsigned ActiveKeys  = NumKeywords < KeyRegs ? NumKeywords : KeyRegs;

  localparam logic [CharW-1:0] ChSpace    = 8'h20;
  localparam logic [CharW-1:0] ChPeriod   = 8'h2E;
  localparam logic [CharW-1:0] ChComma    = 8'h2C;
  localparam logic [CharW-1:0] ChQuestion = 8'h3F;
  localparam logic [CharW-1:0] ChExclaim  = 8'h21;
  localparam logic [CharW-1:0] ChNewline  = 8'h0A;
  localparam logic [CharW-1:0] ChNul      = 8'h00;

  localparam logic [LenW-1:0]   MaxLen     = LenW'(MaxWordLen);
  localparam logic [LenW-1:0]   OverLen    = LenW'(MaxWordLen + 1);
  localparam logic [InUseW-1:0] ActiveMax  = InUseW'(ActiveKeys);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_A   = 3'd0,
    CFG_KEY_B   = 3'd1,
    CFG_KEY_C   = 3'd2,
    CFG_KEY_D   = 3'd3,
    CFG_LENGTHS = 3'd4,
    CFG_IN_USE  = 3'd5
  } cfg_idx_e;

  typedef logic [KeyW-1:0] key_t;

  // Result of one pass of the keyword comparators
  typedef struct packed {
    logic [KeyRegs-1:0] still_next;
    logic [MatchW-1:0]  match_cnt;
  } match_t;

  function automatic logic is_delim(input logic [CharW-1:0] c);
    is_delim = (c == ChSpace) || (c == ChPeriod) || (c == ChComma) ||
               (c == ChQuestion) || (c == ChExclaim);
  endfunction

endpackage

>>> rtl/keyword_token_counter_core.sv
// Keyword token counter: top level with config registers, token state and counters.
// Depends on kwtc_pkg and kwtc_match.
// Each accepted byte gives one result item, registered and valid in the next cycle.
// Throughput: one byte per cycle; the single result register is refilled on the
// cycle it is taken, so the input stalls only while a result waits unread.
// Reset: asynchronous, active low; clears counters, token state and configuration.
module keyword_token_counter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kwtc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kwtc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] char_in
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] total_tokens, [63:32] keyword_hits, [95:64] other_tokens,
  // [96] token_ended, [99:97] matches_now, [103:100] zero
  output logic [103:0]                  m_axis_tdata_o
);
  import kwtc_pkg::*;

  key_t               keys_q [KeyRegs];
  logic [LensW-1:0]   key_lens_q;
  logic [InUseW-1:0]  in_use_q;

  logic [LenW-1:0]    tok_len_q, tok_len_d;
  logic [KeyRegs-1:0] still_q, still_d;
  logic [CntW-1:0]    tok_total_q, tok_total_d;
  logic [CntW-1:0]    hit_total_q, hit_total_d;
  logic               muted_q, muted_d;
  logic               out_valid_q;
  logic               ended_q, ended_d;
  logic [MatchW-1:0]  matches_q, matches_d;

  logic [CharW-1:0]   ch;
  logic               in_acc;
  logic [CntW:0]      tok_sum, hit_sum;
  logic [CntW-1:0]    other;
  match_t             match;

  assign ch              = s_axis_tdata_i[CharW-1:0];
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  kwtc_match u_match (
    .char_i     (ch),
    .tok_len_i  (tok_len_q),
    .still_i    (still_q),
    .keys_i     (keys_q),
    .key_lens_i (key_lens_q),
    .in_use_i   (in_use_q),
    .match_o    (match)
  );

  assign tok_sum = {1'b0, tok_total_q} + (CntW+1)'(1);
  assign hit_sum = {1'b0, hit_total_q} + (CntW+1)'(match.match_cnt);

  always_comb begin
    tok_len_d   = tok_len_q;
    still_d     = still_q;
    tok_total_d = tok_total_q;
    hit_total_d = hit_total_q;
    muted_d     = muted_q;
    ended_d     = 1'b0;
    matches_d   = '0;
    if (ch == ChNewline) begin
      tok_len_d = '0;
      still_d   = '1;
      muted_d   = 1'b0;
    end else if (muted_q) begin
      // ignore the rest of the line
    end else if (ch == ChNul) begin
      tok_len_d = '0;
      still_d   = '1;
      muted_d   = 1'b1;
    end else if (is_delim(ch)) begin
      ended_d     = 1'b1;
      matches_d   = match.match_cnt;
      tok_total_d = tok_sum[CntW] ? '1 : tok_sum[CntW-1:0];
      hit_total_d = hit_sum[CntW] ? '1 : hit_sum[CntW-1:0];
      tok_len_d   = '0;
      still_d     = '1;
    end else if (tok_len_q < MaxLen) begin
      still_d   = match.still_next;
      tok_len_d = tok_len_q + LenW'(1);
    end else begin
      tok_len_d = OverLen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KeyRegs; k++) begin
        keys_q[k] <= '0;
      end
      key_lens_q <= '0;
      in_use_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_A:   keys_q[0]  <= cfg_wdata_i[KeyW-1:0];
        CFG_KEY_B:   keys_q[1]  <= cfg_wdata_i[KeyW-1:0];
        CFG_KEY_C:   keys_q[2]  <= cfg_wdata_i[KeyW-1:0];
        CFG_KEY_D:   keys_q[3]  <= cfg_wdata_i[KeyW-1:0];
        CFG_LENGTHS: key_lens_q <= cfg_wdata_i[LensW-1:0];
        CFG_IN_USE:  in_use_q   <= cfg_wdata_i[InUseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_len_q   <= '0;
      still_q     <= '1;
      tok_total_q <= '0;
      hit_total_q <= '0;
      muted_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ended_q     <= 1'b0;
      matches_q   <= '0;
    end else begin
      if (in_acc) begin
        tok_len_q   <= tok_len_d;
        still_q     <= still_d;
        tok_total_q <= tok_total_d;
        hit_total_q <= hit_total_d;
        muted_q     <= muted_d;
        ended_q     <= ended_d;
        matches_q   <= matches_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Counters only move on accept, which frees the result slot, so they double as result
  assign other = (tok_total_q > hit_total_q) ? (tok_total_q - hit_total_q) : '0;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, matches_q, ended_q, other, hit_total_q, tok_total_q};

endmodule

>>> rtl/kwtc_match.sv
// Parallel keyword comparators: per-keyword byte compare and match count.
// Depends on kwtc_pkg.
module kwtc_match (
  input  logic [kwtc_pkg::CharW-1:0]   char_i,
  input  logic [kwtc_pkg::LenW-1:0]    tok_len_i,
  input  logic [kwtc_pkg::KeyRegs-1:0] still_i,
  input  kwtc_pkg::key_t               keys_i [kwtc_pkg::KeyRegs],
  input  logic [kwtc_pkg::LensW-1:0]   key_lens_i,
  input  logic [kwtc_pkg::InUseW-1:0]  in_use_i,
  output kwtc_pkg::match_t             match_o
);
  import kwtc_pkg::*;

  logic [InUseW-1:0]  active;
  logic [PosW-1:0]    pos;
  logic [KeyRegs-1:0] hit;
  logic               len_ok;

  // Clamp the number of keywords taking part
  assign active = (in_use_i > ActiveMax) ? ActiveMax : in_use_i;
  assign pos    = tok_len_i[PosW-1:0];
  assign len_ok = (tok_len_i <= MaxLen);

  always_comb begin
    match_o.match_cnt = '0;
    for (int k = 0; k < KeyRegs; k++) begin
      match_o.still_next[k] = still_i[k] && (keys_i[k][pos*CharW +: CharW] == char_i);
      hit[k] = still_i[k] && len_ok && (key_lens_i[k*LenW +: LenW] == tok_len_i) &&
               (InUseW'(k) < active);
    end
    for (int k = 0; k < KeyRegs; k++) begin
      match_o.match_cnt = match_o.match_cnt + MatchW'(hit[k]);
    end
  end

endmodule

>>> bench/keyword_token_counter_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for keyword_token_counter_core: streams text bytes, predicts the
// running token and keyword-hit counts and compares every result item field by field.
// Depends on kwtc_pkg and the core RTL.
module keyword_token_counter_core_tb;
  import kwtc_pkg::*;

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned KeyIdxW       = $clog2(KeyRegs);
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam logic [CharW-1:0]   ChLetterA  = 8'h61;

  // Result item as packed on m_axis_tdata_o
  typedef struct packed {
    logic [3:0]        pad;
    logic [MatchW-1:0] matches_now;
    logic              token_ended;
    logic [CntW-1:0]   other_tokens;
    logic [CntW-1:0]   keyword_hits;
    logic [CntW-1:0]   total_tokens;
  } tally_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = '0;  // [7:0] char_in
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [31:0] total_tokens, [63:32] keyword_hits, [95:64] other_tokens,
  // [96] token_ended, [99:97] matches_now, [103:100] zero
  logic [103:0]        m_axis_tdata_o;

  keyword_token_counter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predictor copy of configuration and token state
  logic [KeyW-1:0]    key_shadow [KeyRegs];
  logic [LensW-1:0]   lens_shadow;
  logic [InUseW-1:0]  in_use_shadow;
  logic [LenW-1:0]    tok_len;
  logic [KeyRegs-1:0] still_hit;
  logic [CntW-1:0]    tok_total;
  logic [CntW-1:0]    hit_total;
  logic               line_muted;
  tally_t             expected_tallies [$];

  int err_cnt = 0;
  int sent_items = 0;
  int checked_results = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  function automatic logic ends_token(input logic [CharW-1:0] c);
    return c inside {ChSpace, ChPeriod, ChComma, ChQuestion, ChExclaim};
  endfunction

  function automatic logic [CharW-1:0] delim_at(input int unsigned i);
    case (i)
      0:       return ChSpace;
      1:       return ChPeriod;
      2:       return ChComma;
      3:       return ChQuestion;
      default: return ChExclaim;
    endcase
  endfunction

  function automatic logic [CharW-1:0] letter();
    return ChLetterA + CharW'($urandom_range(3));
  endfunction

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                               input int unsigned b);
    logic [CntW:0] s;
    s = a + b;
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

  function automatic logic [KeyW-1:0] pack_text(input string s);
    logic [KeyW-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < MaxWordLen; i++) v[CharW*i +: CharW] = s[i];
    return v;
  endfunction

  // Advance the token state by one byte and queue the result item it gives
  task automatic tally_char(input logic [CharW-1:0] c);
    tally_t      t;
    int unsigned n_active;
    int unsigned hits;
    t = '0;
    hits = 0;
    n_active = (in_use_shadow > NumKeywords) ? NumKeywords : in_use_shadow;
    if (n_active > KeyRegs) n_active = KeyRegs;
    if (c == ChNewline) begin
      tok_len = '0;
      still_hit = '1;
      line_muted = 1'b0;
    end else if (!line_muted) begin
      if (c == ChNul) begin
        tok_len = '0;
        still_hit = '1;
        line_muted = 1'b1;
      end else if (ends_token(c)) begin
        for (int k = 0; k < n_active; k++)
          if (still_hit[k] && tok_len <= MaxWordLen &&
              lens_shadow[LenW*k +: LenW] == tok_len) hits++;
        t.token_ended = 1'b1;
        t.matches_now = MatchW'(hits);
        tok_total = sat_add(tok_total, 1);
        hit_total = sat_add(hit_total, hits);
        tok_len = '0;
        still_hit = '1;
      end else if (tok_len < MaxWordLen) begin
        for (int k = 0; k < KeyRegs; k++)
          if (key_shadow[k][CharW*tok_len +: CharW] != c) still_hit[k] = 1'b0;
        tok_len++;
      end else begin
        tok_len = OverLen;
      end
    end
    t.total_tokens = tok_total;
    t.keyword_hits = hit_total;
    t.other_tokens = (tok_total > hit_total) ? tok_total - hit_total : '0;
    expected_tallies.push_back(t);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_KEY_A, CFG_KEY_B, CFG_KEY_C, CFG_KEY_D: key_shadow[idx[KeyIdxW-1:0]] = val;
      CFG_LENGTHS: lens_shadow = val[LensW-1:0];
      CFG_IN_USE:  in_use_shadow = val[InUseW-1:0];
      default: ;  // spare indexes leave the block untouched
    endcase
  endtask

  task automatic send_char(input logic [CharW-1:0] c);
    @(negedge clk_i);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tally_char(c);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid and hold until every queued result item has been taken
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (expected_tallies.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // One token built mostly from a configured keyword, then usually a terminator
  task automatic send_word();
    int unsigned pick;
    int unsigned k;
    int unsigned wl;
    logic [CharW-1:0] c;
    pick = $urandom_range(99);
    k = $urandom_range(KeyRegs - 1);
    wl = lens_shadow[LenW*k +: LenW];
    if (wl > MaxWordLen || pick < 15) wl = $urandom_range(MaxWordLen + 3);
    for (int i = 0; i < wl; i++) begin
      c = (i < MaxWordLen) ? key_shadow[k][CharW*i +: CharW] : letter();
      if (pick >= 15 && pick < 30 && $urandom_range(3) == 0) c = letter();
      send_char(c);
    end
    pick = $urandom_range(99);
    if (pick < 85) begin
      send_char(delim_at($urandom_range(4)));
    end else if (pick < 93) begin
      send_char(ChNewline);
    end else if (pick < 97) begin
      send_char(ChNul);
      repeat ($urandom_range(2)) send_char(CharW'($urandom_range(255)));
      send_char(ChNewline);
    end else begin
      send_char(CharW'($urandom_range(255)));
    end
  endtask

  task automatic run_stream(input int n_items);
    int start;
    start = sent_items;
    while (sent_items - start < n_items) begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 6)) send_char(CharW'($urandom_range(255)));
      else
        send_word();
    end
    wait_drain();
  endtask

  task automatic load_random_keywords();
    logic [KeyW-1:0]   key;
    logic [LensW-1:0]  lens;
    logic [LenW-1:0]   kl;
    logic [InUseW-1:0] n_use;
    lens = '0;
    key = '0;
    kl = '0;
    for (int k = 0; k < KeyRegs; k++) begin
      // now and then repeat the previous keyword so it counts twice
      if (k == 0 || $urandom_range(5) != 0) begin
        key = {$urandom, $urandom};
        for (int i = 0; i < MaxWordLen; i++)
          if ($urandom_range(3) != 0) key[CharW*i +: CharW] = letter();
        kl = ($urandom_range(9) == 0) ? LenW'($urandom_range(MaxWordLen + 1, 15))
                                      : LenW'($urandom_range(MaxWordLen));
      end
      lens[LenW*k +: LenW] = kl;
      write_reg(CfgIdxW'(CFG_KEY_A + k), key);
    end
    n_use = ($urandom_range(3) == 0) ? InUseW'($urandom_range(7)) : ActiveMax;
    write_reg(CFG_LENGTHS, KeyW'(lens));
    write_reg(CFG_IN_USE, KeyW'(n_use));
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int n_items);
    load_random_keywords();
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    run_stream(n_items);
  endtask

  // Reset configuration: no keyword takes part, so tokens count with no hits
  task automatic test_after_reset();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_text(". a,");
    wait_drain();
  endtask

  task automatic test_directed_keywords();
    write_reg(CFG_KEY_A, pack_text("the"));
    write_reg(CFG_KEY_B, pack_text("concaten"));
    write_reg(CFG_KEY_C, pack_text("the"));
    write_reg(CFG_KEY_D, pack_text("zz"));
    write_reg(CFG_LENGTHS, KeyW'({4'd0, 4'd3, MaxLen, 4'd3}));
    write_reg(CFG_IN_USE, KeyW'(ActiveMax));
    write_reg(CfgSpareLo, '1);
    write_reg(CfgSpareHi, '1);
    send_text("the ");        // duplicate keyword scores twice
    send_text(",");           // empty token against a zero-length keyword
    send_text("concaten?");   // full eight-byte keyword
    send_text("concatenx!");  // overlong token
    send_text("a\n");         // newline drops the open token
    send_text("a");
    send_char(ChNul);         // mute the rest of the line
    send_text("e.\n");
    wait_drain();
  endtask

  task automatic test_random_phases();
    run_phase(0, 0, 60);
    run_phase(52, 0, 60);
    run_phase(0, 52, 60);
    run_phase(25, 25, 60);
  endtask

  task automatic test_extreme_keys();
    src_idle_pct = 25;
    sink_stall_pct = 25;
    for (int k = 0; k < KeyRegs; k++) write_reg(CfgIdxW'(CFG_KEY_A + k), '1);
    write_reg(CFG_LENGTHS, KeyW'({KeyRegs{MaxLen}}));
    write_reg(CFG_IN_USE, KeyW'(ActiveMax));
    run_stream(25);
    // zero-length keywords with the in-use count at its field maximum:
    // every empty token scores on all keywords, so hits outrun tokens
    for (int k = 0; k < KeyRegs; k++) write_reg(CfgIdxW'(CFG_KEY_A + k), '0);
    write_reg(CFG_LENGTHS, '0);
    write_reg(CFG_IN_USE, '1);
    run_stream(15);
    // lengths above the word limit never match
    write_reg(CFG_LENGTHS, KeyW'({LensW{1'b1}}));
    run_stream(15);
  endtask

  task automatic test_backpressure();
    load_random_keywords();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = HoldOffCycles;
    run_stream(40);
  endtask

  task automatic test_drain_pause();
    load_random_keywords();
    src_idle_pct = 0;
    sink_stall_pct = 52;
    run_stream(20);
    run_stream(20);
  endtask

  // Receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready_i = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [CntW-1:0] want,
                             input logic [CntW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : check_result
    tally_t got;
    tally_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (expected_tallies.size() == 0) begin
        $error("result item with none expected: %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        want = expected_tallies.pop_front();
        check_field("total_tokens", want.total_tokens, got.total_tokens);
        check_field("keyword_hits", want.keyword_hits, got.keyword_hits);
        check_field("other_tokens", want.other_tokens, got.other_tokens);
        check_field("token_ended", CntW'(want.token_ended), CntW'(got.token_ended));
        check_field("matches_now", CntW'(want.matches_now), CntW'(got.matches_now));
        checked_results++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < KeyRegs; k++) key_shadow[k] = '0;
    lens_shadow = '0;
    in_use_shadow = '0;
    tok_len = '0;
    still_hit = '1;
    tok_total = '0;
    hit_total = '0;
    line_muted = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_directed_keywords();
    test_random_phases();
    test_extreme_keys();
    test_backpressure();
    test_drain_pause();

    wait_drain();
    repeat (TailCycles) @(negedge clk_i);
    if (expected_tallies.size() != 0) begin
      $error("%0d result items never arrived", expected_tallies.size());
      err_cnt++;
    end
    $display("Streamed %0d text bytes and checked %0d result items under mixed stalls,",
             sent_items, checked_results);
    $display("ending at %0d tokens and %0d keyword hits.", tok_total, hit_total);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
